[rtl/mrtb_pkg.sv]
// ----------------------------------------------------------------------------
// mrtb_pkg - shared definitions for the minimal-radix token converter
// Character classes, digit decoding, status codes and default sizes.
// ----------------------------------------------------------------------------
package mrtb_pkg;

    // Default depth of the digit buffer.
    localparam int MAX_LEN_DEF = 32;

    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 6;
    localparam int RADIX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

    // Decoded character: ok is set for a letter or a decimal digit.
    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } digit_t;

    // Whitespace (tab to carriage return, space) and the byte 0xFF.
    function automatic logic is_separator(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'hFF);
    endfunction

    // Digits give 0 to 9, letters of either case give 10 to 35.
    function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
        digit_t           d;
        logic [CHAR_W-1:0] t;
        d = '0;
        t = '0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            t = c - 8'h30;
            d.ok = 1'b1;
        end else if ((c >= 8'h41) && (c <= 8'h5A)) begin
            t = c - 8'h37;
            d.ok = 1'b1;
        end else if ((c >= 8'h61) && (c <= 8'h7A)) begin
            t = c - 8'h57;
            d.ok = 1'b1;
        end
        d.val = t[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

[rtl/min_radix_token_to_binary.sv]
// ----------------------------------------------------------------------------
// min_radix_token_to_binary - character stream to minimal-radix integers
// Gathers alphanumeric tokens, then converts each in its smallest radix.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata                          tuser         tlast
//  s_       in         [7:0] char_code                -             end_of_input
//  m_       out        [5:0] radix, [37:6] value      [1:0] status  -
//
// A character word is taken while the block is idle; digits are written into
// the digit buffer in the same cycle. Closing a token of n buffered digits
// walks the buffer through one shared multiply-add unit, one digit per cycle,
// and the result word appears when the walk ends. A bad character gives its
// result word at once. The input is stalled while a walk runs, and while a
// result word is held back by m_tready. Reset (aresetn low at a clock edge)
// clears the token state and any pending result; the digit buffer needs no
// clearing.
// ----------------------------------------------------------------------------
module min_radix_token_to_binary #(
    parameter int MAX_LEN = mrtb_pkg::MAX_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_input

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [5:0] radix, [37:6] value, [39:38] zero
    output logic [7:0]  m_tuser    // [1:0] status, [7:2] zero
);

    // Address width of the buffer and width of the length counter, which must
    // also hold MAX_LEN itself.
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = mrtb_pkg::DIGIT_W;
    localparam int VW = mrtb_pkg::VALUE_W;
    localparam int RW = mrtb_pkg::RADIX_W;
    localparam int SW = mrtb_pkg::STATUS_W;

    // Sequencer: idle takes characters, walk converts the buffered token.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                state_reg, state_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [DW-1:0]       largest_reg, largest_next;
    logic                overlong_reg, overlong_next;
    logic [LW-1:0]       rd_idx_reg, rd_idx_next;
    logic                mac_v_reg, mac_v_next;
    logic [VW-1:0]       acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic [RW-1:0]       out_radix_reg, out_radix_next;
    logic [VW-1:0]       out_value_reg, out_value_next;
    logic [SW-1:0]       out_status_reg, out_status_next;
    logic [DW-1:0]       rd_data_reg;

    // Digit buffer; entries at and above the token length are never read.
    logic [DW-1:0]       digit_mem [MAX_LEN];

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DW-1:0]       wr_data;
    logic                rd_en;

    logic                accept;
    logic                out_free;
    logic                sep;
    mrtb_pkg::digit_t    dig;
    logic [RW-1:0]       radix_cur;
    logic [VW+RW-1:0]    prod;
    logic [VW-1:0]       mac;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign sep = mrtb_pkg::is_separator(s_tdata);
    assign dig = mrtb_pkg::digit_of(s_tdata);

    // The shared unit: one multiply by the radix and one add of a digit.
    assign radix_cur = RW'(largest_reg) + RW'(1);
    assign prod      = acc_reg * radix_cur;
    assign mac       = prod[VW-1:0] + VW'(rd_data_reg);

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        largest_next    = largest_reg;
        overlong_next   = overlong_reg;
        rd_idx_next     = rd_idx_reg;
        mac_v_next      = mac_v_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_radix_next  = out_radix_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = len_reg[AW-1:0];
        wr_data         = dig.val;
        rd_en           = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (sep) begin
                        // A separator closes a pending token; end mark adds nothing.
                        if (len_reg != '0) begin
                            state_next  = ST_WALK;
                            rd_idx_next = '0;
                            mac_v_next  = 1'b0;
                            acc_next    = '0;
                        end
                    end else if (!dig.ok) begin
                        // Bad character: report it and drop the token.
                        out_valid_next  = 1'b1;
                        out_radix_next  = '0;
                        out_value_next  = '0;
                        out_status_next = mrtb_pkg::STATUS_BAD_CHAR;
                        len_next        = '0;
                        largest_next    = '0;
                        overlong_next   = 1'b0;
                    end else begin
                        if (len_reg < LW'(MAX_LEN)) begin
                            wr_en    = 1'b1;
                            len_next = len_reg + LW'(1);
                            if (dig.val > largest_reg) begin
                                largest_next = dig.val;
                            end
                        end else begin
                            overlong_next = 1'b1;
                        end
                        // The token holds at least this digit or the earlier ones.
                        if (s_tlast) begin
                            state_next  = ST_WALK;
                            rd_idx_next = '0;
                            mac_v_next  = 1'b0;
                            acc_next    = '0;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (mac_v_reg) begin
                    acc_next = mac;
                end
                if (rd_idx_reg < len_reg) begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + LW'(1);
                    mac_v_next  = 1'b1;
                end else begin
                    // Last digit is in the unit: the output register is free here.
                    out_valid_next  = 1'b1;
                    out_radix_next  = radix_cur;
                    out_value_next  = mac;
                    out_status_next = overlong_reg ? mrtb_pkg::STATUS_TOO_LONG
                                                   : mrtb_pkg::STATUS_OK;
                    mac_v_next      = 1'b0;
                    len_next        = '0;
                    largest_next    = '0;
                    overlong_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            largest_reg   <= '0;
            overlong_reg  <= 1'b0;
            mac_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            largest_reg   <= largest_next;
            overlong_reg  <= overlong_next;
            mac_v_reg     <= mac_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        acc_reg        <= acc_next;
        out_radix_reg  <= out_radix_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= digit_mem[rd_idx_reg[AW-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_radix_reg};
    assign m_tuser  = {6'b000000, out_status_reg};

    // A bad-character word carries neither radix nor value.
    a_bad_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg == mrtb_pkg::STATUS_BAD_CHAR))
            |-> ((out_radix_reg == '0) && (out_value_reg == '0)))
        else $error("bad-character word with nonzero payload");

    // A converted token always has a radix between one and thirty-six.
    a_radix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg != mrtb_pkg::STATUS_BAD_CHAR))
            |-> ((out_radix_reg != '0) && (out_radix_reg <= RW'(36))))
        else $error("converted word with radix out of range");

    // The buffer never holds more than MAX_LEN digits.
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_LEN))
        else $error("token length beyond buffer depth");

    // A walk only starts with a non-empty token and never reads past it.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> ((len_reg != '0) && (rd_idx_reg <= len_reg)))
        else $error("walk index outside the buffered token");

endmodule
